// ----- sv/mm4_pkg.sv -----
package mm4_pkg;

   // Matrix geometry
   localparam int DIM    = 4;
   localparam int ELEMS  = DIM * DIM;
   localparam int IDX_W  = 4;
   localparam int SUB_W  = 2;

   // Datapath widths: Q16.16 elements, exact products, exact sum of four products
   localparam int VAL_W  = 32;
   localparam int PROD_W = 2 * VAL_W;
   localparam int SUM_W  = PROD_W + 2;

   // Request codes
   localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] REQ_COMPUTE    = 2'd2;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_DRAIN
   } seq_state_type;

   // Element tag that travels down the cell chain with its partial sum
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] index;
   } tag_type;

   // Store write port of one cell
   typedef struct packed {
      logic             left_en;
      logic             right_en;
      logic [SUB_W-1:0] addr;
      logic [VAL_W-1:0] value;
   } wr_type;

endpackage

// ----- sv/mm4_cell.sv -----
module mm4_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mm4_pkg::wr_type                       wr,
   input  mm4_pkg::tag_type                      tag_in,
   input  logic signed [mm4_pkg::SUM_W-1:0]      sum_in,
   output mm4_pkg::tag_type                      tag_out,
   output logic signed [mm4_pkg::SUM_W-1:0]      sum_out
);

   // Cell i holds left column i (indexed by row) and right row i (indexed by col)
   logic signed [mm4_pkg::VAL_W-1:0]  left_ff  [mm4_pkg::DIM];
   logic signed [mm4_pkg::VAL_W-1:0]  right_ff [mm4_pkg::DIM];

   logic signed [mm4_pkg::VAL_W-1:0]  left_sel;
   logic signed [mm4_pkg::VAL_W-1:0]  right_sel;
   logic signed [mm4_pkg::PROD_W-1:0] prod_in;
   logic signed [mm4_pkg::PROD_W-1:0] prod_ff;
   mm4_pkg::tag_type                  tag1_ff;
   logic signed [mm4_pkg::SUM_W-1:0]  sum1_ff;
   logic signed [mm4_pkg::SUM_W-1:0]  sum2_in;
   mm4_pkg::tag_type                  tag2_ff;
   logic signed [mm4_pkg::SUM_W-1:0]  sum2_ff;

   // Write the local stores; both reset to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mm4_pkg::DIM; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= '0;
         end
      end else begin
         if (wr.left_en) begin
            left_ff[wr.addr] <= wr.value;
         end
         if (wr.right_en) begin
            right_ff[wr.addr] <= wr.value;
         end
      end
   end

   // Select operands by the row and column of the passing element
   assign left_sel  = left_ff[tag_in.index[mm4_pkg::SUB_W-1:0]];
   assign right_sel = right_ff[tag_in.index[mm4_pkg::IDX_W-1:mm4_pkg::SUB_W]];
   assign prod_in   = left_sel * right_sel;

   // Stage one: register the product, carry the incoming sum along
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
      end else begin
         tag1_ff.valid <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      tag1_ff.index <= tag_in.index;
      prod_ff       <= prod_in;
      sum1_ff       <= sum_in;
   end

   // Stage two: accumulate and hand on to the next cell
   assign sum2_in = sum1_ff +
      {{(mm4_pkg::SUM_W-mm4_pkg::PROD_W){prod_ff[mm4_pkg::PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.valid <= 1'b0;
      end else begin
         tag2_ff.valid <= tag1_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      tag2_ff.index <= tag1_ff.index;
      sum2_ff       <= sum2_in;
   end

   assign tag_out = tag2_ff;
   assign sum_out = sum2_ff;

endmodule

// ----- sv/mm4_seq.sv -----
module mm4_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic             done,
   output logic             busy,
   output mm4_pkg::tag_type tag
);

   mm4_pkg::seq_state_type        state_ff;
   mm4_pkg::seq_state_type        state_in;
   logic [mm4_pkg::IDX_W-1:0]     cnt_ff;
   logic [mm4_pkg::IDX_W-1:0]     cnt_in;
   logic                          cnt_end;

   assign cnt_end = (cnt_ff == mm4_pkg::IDX_W'(mm4_pkg::ELEMS - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mm4_pkg::SEQ_IDLE: begin
            if (go) begin
               state_in = mm4_pkg::SEQ_ISSUE;
            end
         end
         mm4_pkg::SEQ_ISSUE: begin
            if (cnt_end) begin
               state_in = mm4_pkg::SEQ_DRAIN;
            end
         end
         mm4_pkg::SEQ_DRAIN: begin
            if (done) begin
               state_in = mm4_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = mm4_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Outputs: issue one element index per cycle while in ISSUE
   always_comb begin
      busy      = 1'b1;
      tag.valid = 1'b0;
      tag.index = cnt_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         mm4_pkg::SEQ_IDLE: begin
            busy   = 1'b0;
            cnt_in = '0;
         end
         mm4_pkg::SEQ_ISSUE: begin
            tag.valid = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
         end
         mm4_pkg::SEQ_DRAIN: begin
            cnt_in = '0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm4_pkg::SEQ_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- sv/mm4_out.sv -----
module mm4_out #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mm4_pkg::tag_type                      tag_in,
   input  logic signed [mm4_pkg::SUM_W-1:0]      sum_in,
   output logic                                  strobe,
   output logic [mm4_pkg::IDX_W-1:0]             index,
   output logic signed [mm4_pkg::VAL_W-1:0]      value,
   output logic                                  last
);

   logic signed [mm4_pkg::SUM_W-1:0] shifted;
   logic                             sign;
   logic                             fits;
   logic signed [mm4_pkg::VAL_W-1:0] value_in;
   logic                             strobe_ff;
   logic [mm4_pkg::IDX_W-1:0]        index_ff;
   logic signed [mm4_pkg::VAL_W-1:0] value_ff;
   logic                             last_ff;

   // Floor shift, then clamp to the signed 32-bit range
   assign shifted = sum_in >>> FRAC_BITS;
   assign sign    = shifted[mm4_pkg::SUM_W-1];
   assign fits    = sign ? (&shifted[mm4_pkg::SUM_W-1:mm4_pkg::VAL_W-1])
                         : ~(|shifted[mm4_pkg::SUM_W-1:mm4_pkg::VAL_W-1]);

   always_comb begin
      priority if (fits) begin
         value_in = shifted[mm4_pkg::VAL_W-1:0];
      end else if (sign) begin
         value_in = {1'b1, {(mm4_pkg::VAL_W-1){1'b0}}};
      end else begin
         value_in = {1'b0, {(mm4_pkg::VAL_W-1){1'b1}}};
      end
   end

   // Register the result transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= tag_in.index;
      value_ff <= value_in;
      last_ff  <= (tag_in.index == mm4_pkg::IDX_W'(mm4_pkg::ELEMS - 1));
   end

   assign strobe = strobe_ff;
   assign index  = index_ff;
   assign value  = value_ff;
   assign last   = last_ff;

endmodule

// ----- sv/matrix4x4_multiply.sv -----
// Load requests: one transfer per cycle while not busy, written to the stores at the
// accepting edge. Compute request: 16 results follow on consecutive cycles, in index
// order, after the 4-cell chain (2 stages per cell) and the output register; busy holds
// from the accepting edge until the last result, so no request is taken before then.
// The receiver cannot stall: each result is on the rsp_ ports for one cycle only.
// Synchronous reset clears both matrix stores to zero and empties the cell chain.
module matrix4x4_multiply #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_type,
   input  logic [mm4_pkg::IDX_W-1:0]             req_elem_index,
   input  logic signed [mm4_pkg::VAL_W-1:0]      req_elem_value,
   output logic                                  rsp_strobe,
   output logic [mm4_pkg::IDX_W-1:0]             rsp_out_index,
   output logic signed [mm4_pkg::VAL_W-1:0]      rsp_out_value,
   output logic                                  rsp_out_last
);

   logic                             accept;
   logic                             load_left;
   logic                             load_right;
   logic                             go;
   logic                             done;
   mm4_pkg::tag_type                 tag_w [mm4_pkg::DIM+1];
   logic signed [mm4_pkg::SUM_W-1:0] sum_w [mm4_pkg::DIM+1];
   mm4_pkg::wr_type                  wr_w  [mm4_pkg::DIM];

   // Decode the request transfer
   assign accept     = start && !busy;
   assign load_left  = accept && (req_type == mm4_pkg::REQ_LOAD_LEFT);
   assign load_right = accept && (req_type == mm4_pkg::REQ_LOAD_RIGHT);
   assign go         = accept && (req_type == mm4_pkg::REQ_COMPUTE);
   assign done       = rsp_strobe && rsp_out_last;

   mm4_seq u_seq (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .done  (done),
      .busy  (busy),
      .tag   (tag_w[0])
   );

   assign sum_w[0] = '0;

   // Chain of cells: cell i adds left[i*4+row] * right[col*4+i]
   for (genvar i = 0; i < mm4_pkg::DIM; i++) begin : g_cell
      assign wr_w[i].left_en  = load_left &&
         (req_elem_index[mm4_pkg::IDX_W-1:mm4_pkg::SUB_W] == mm4_pkg::SUB_W'(i));
      assign wr_w[i].right_en = load_right &&
         (req_elem_index[mm4_pkg::SUB_W-1:0] == mm4_pkg::SUB_W'(i));
      assign wr_w[i].addr     = load_left ? req_elem_index[mm4_pkg::SUB_W-1:0]
                                          : req_elem_index[mm4_pkg::IDX_W-1:mm4_pkg::SUB_W];
      assign wr_w[i].value    = req_elem_value;

      mm4_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr      (wr_w[i]),
         .tag_in  (tag_w[i]),
         .sum_in  (sum_w[i]),
         .tag_out (tag_w[i+1]),
         .sum_out (sum_w[i+1])
      );
   end

   mm4_out #(
      .FRAC_BITS (FRAC_BITS)
   ) u_out (
      .clock  (clock),
      .reset  (reset),
      .tag_in (tag_w[mm4_pkg::DIM]),
      .sum_in (sum_w[mm4_pkg::DIM]),
      .strobe (rsp_strobe),
      .index  (rsp_out_index),
      .value  (rsp_out_value),
      .last   (rsp_out_last)
   );

   // Results only appear during a compute
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result transfer while not busy");

   // Results stream back to back in index order
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_out_last |=>
         rsp_strobe && (rsp_out_index == $past(rsp_out_index) + 4'd1))
      else $error("result stream broken");

   // Busy drops right after the last result
   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_out_last |=> !busy)
      else $error("busy held after last result");

   // A compute transfer makes the block busy
   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      go |=> busy && !rsp_strobe)
      else $error("compute not started");

endmodule

// ----- tb/tb.sv -----
module tb;

   localparam int FRAC         = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   // Request code that the block must ignore
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Saturation bounds at accumulator width
   localparam logic signed [mm4_pkg::SUM_W-1:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [mm4_pkg::SUM_W-1:0] SAT_LO = -66'sd2147483648;
   localparam logic signed [mm4_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
   localparam logic signed [mm4_pkg::VAL_W-1:0] VAL_MIN = 32'sh80000000;

   typedef struct {
      logic [mm4_pkg::IDX_W-1:0]        index;
      logic signed [mm4_pkg::VAL_W-1:0] value;
      logic                             last;
   } product_elem_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [1:0]                       req_type = mm4_pkg::REQ_LOAD_LEFT;
   logic [mm4_pkg::IDX_W-1:0]        req_elem_index = '0;
   logic signed [mm4_pkg::VAL_W-1:0] req_elem_value = '0;
   logic                             rsp_strobe;
   logic [mm4_pkg::IDX_W-1:0]        rsp_out_index;
   logic signed [mm4_pkg::VAL_W-1:0] rsp_out_value;
   logic                             rsp_out_last;

   // Shadow copies of the two matrix stores and the queue of pending products
   logic signed [mm4_pkg::VAL_W-1:0] left_mat [mm4_pkg::ELEMS];
   logic signed [mm4_pkg::VAL_W-1:0] right_mat[mm4_pkg::ELEMS];
   product_elem_type                 product_queue[$];

   int idle_pct;
   int error_count;
   int sent_count;
   int compute_count;
   int checked_count;

   matrix4x4_multiply #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stop a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $error("timeout after %0d cycles, %0d products pending", CYCLE_LIMIT,
             product_queue.size());
      $display("tb NOT OK");
      $finish;
   end

   // Dot product of one row of left with one column of right, floor shift, saturate
   function automatic logic signed [mm4_pkg::VAL_W-1:0] product_element(int col, int row);
      logic signed [mm4_pkg::PROD_W-1:0] prod;
      logic signed [mm4_pkg::SUM_W-1:0]  acc;
      logic signed [mm4_pkg::SUM_W-1:0]  shifted;
      acc = '0;
      for (int i = 0; i < mm4_pkg::DIM; i++) begin
         prod = left_mat[i*mm4_pkg::DIM + row] * right_mat[col*mm4_pkg::DIM + i];
         acc  = acc + prod;
      end
      shifted = acc >>> FRAC;
      if (shifted > SAT_HI) return VAL_MAX;
      if (shifted < SAT_LO) return VAL_MIN;
      return shifted[mm4_pkg::VAL_W-1:0];
   endfunction

   // Update the shadow stores, or queue all 16 products for a compute
   task automatic apply_request(input logic [1:0] kind,
                                input logic [mm4_pkg::IDX_W-1:0] idx,
                                input logic signed [mm4_pkg::VAL_W-1:0] val);
      product_elem_type elem;
      case (kind)
         mm4_pkg::REQ_LOAD_LEFT:  left_mat[idx] = val;
         mm4_pkg::REQ_LOAD_RIGHT: right_mat[idx] = val;
         mm4_pkg::REQ_COMPUTE: begin
            for (int col = 0; col < mm4_pkg::DIM; col++) begin
               for (int row = 0; row < mm4_pkg::DIM; row++) begin
                  elem.index = mm4_pkg::IDX_W'(col*mm4_pkg::DIM + row);
                  elem.value = product_element(col, row);
                  elem.last  = (col*mm4_pkg::DIM + row == mm4_pkg::ELEMS - 1);
                  product_queue.push_back(elem);
               end
            end
            compute_count++;
         end
         default: ;
      endcase
   endtask

   // Drive one request and hold it until the block takes the transfer
   task automatic send_item(input logic [1:0] kind,
                            input logic [mm4_pkg::IDX_W-1:0] idx,
                            input logic signed [mm4_pkg::VAL_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_type       = kind;
      req_elem_index = idx;
      req_elem_value = val;
      start          = 1'b1;
      // Busy only moves at the rising edge, so check it at the falling edge
      while (busy) @(negedge clock);
      @(posedge clock);
      apply_request(kind, idx, val);
      sent_count++;
      @(negedge clock);
   endtask

   // Hold the sender off until every queued product has come back
   task automatic wait_drained();
      start = 1'b0;
      while (product_queue.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [mm4_pkg::VAL_W-1:0] random_value();
      case ($urandom_range(5))
         0: return $signed($urandom) >>> $urandom_range(8, 24);
         1: return VAL_MAX;
         2: return VAL_MIN;
         3: return $urandom_range(1) ? 32'sh00010000 : -32'sh00010000;
         4: return $signed($urandom) >>> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Compare each strobed product with the oldest pending one
   always @(posedge clock) begin : check_products
      product_elem_type want;
      if (!reset && rsp_strobe) begin
         if (product_queue.size() == 0) begin
            $error("unexpected product: index %0d value %0d last %0b",
                   rsp_out_index, rsp_out_value, rsp_out_last);
            error_count++;
         end else begin
            want = product_queue.pop_front();
            if (rsp_out_index !== want.index) begin
               $error("out_index: expected %0d, got %0d", want.index, rsp_out_index);
               error_count++;
            end
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %0d, got %0d", want.value, rsp_out_value);
               error_count++;
            end
            if (rsp_out_last !== want.last) begin
               $error("out_last: expected %0b, got %0b", want.last, rsp_out_last);
               error_count++;
            end
            checked_count++;
         end
      end
   end

   // Both stores come out of reset as zero
   task automatic test_reset_product();
      send_item(mm4_pkg::REQ_COMPUTE, '0, '0);
   endtask

   // Unused code must leave the stores alone; compute ignores its index and value
   task automatic test_ignored_codes();
      send_item(REQ_UNUSED, 4'hF, 32'hFFFFFFFF);
      send_item(REQ_UNUSED, 4'h0, 32'h00000000);
      send_item(mm4_pkg::REQ_COMPUTE, 4'hA, 32'h5A5A5A5A);
   endtask

   // Negative sums round toward minus infinity
   task automatic test_floor_rounding();
      send_item(mm4_pkg::REQ_LOAD_LEFT, 4'd0, -32'sd1);
      send_item(mm4_pkg::REQ_LOAD_RIGHT, 4'd0, 32'sd1);
      send_item(mm4_pkg::REQ_LOAD_LEFT, 4'd5, -32'sd3);
      send_item(mm4_pkg::REQ_LOAD_RIGHT, 4'd5, 32'sd32768);
      send_item(mm4_pkg::REQ_COMPUTE, 4'hF, -32'sd1);
   endtask

   // Drive element 15 into positive and negative saturation
   task automatic test_saturation();
      send_item(mm4_pkg::REQ_LOAD_LEFT, 4'd15, VAL_MAX);
      send_item(mm4_pkg::REQ_LOAD_RIGHT, 4'd15, VAL_MAX);
      send_item(mm4_pkg::REQ_COMPUTE, 4'd0, '0);
      send_item(mm4_pkg::REQ_LOAD_LEFT, 4'd15, VAL_MIN);
      send_item(mm4_pkg::REQ_COMPUTE, 4'd0, '0);
      send_item(mm4_pkg::REQ_LOAD_RIGHT, 4'd15, VAL_MIN);
      send_item(mm4_pkg::REQ_COMPUTE, 4'd0, '0);
   endtask

   // Mostly single-element loads, with whole-matrix loads, computes and unused codes
   task automatic test_random_traffic(input int pct, input int count);
      int         n;
      int         pick;
      logic [1:0] side;
      bit         paused;
      n        = 0;
      paused   = 1'b0;
      idle_pct = pct;
      while (n < count) begin
         pick = $urandom_range(99);
         side = $urandom_range(1) ? mm4_pkg::REQ_LOAD_RIGHT : mm4_pkg::REQ_LOAD_LEFT;
         if (pick < 10) begin
            for (int k = 0; k < mm4_pkg::ELEMS; k++)
               send_item(side, mm4_pkg::IDX_W'(k), random_value());
            send_item(mm4_pkg::REQ_COMPUTE, mm4_pkg::IDX_W'($urandom), $urandom);
            n += mm4_pkg::ELEMS + 1;
         end else if (pick < 25) begin
            send_item(mm4_pkg::REQ_COMPUTE, mm4_pkg::IDX_W'($urandom), $urandom);
            n++;
         end else if (pick < 28) begin
            send_item(REQ_UNUSED, mm4_pkg::IDX_W'($urandom), $urandom);
         end else begin
            send_item(side, mm4_pkg::IDX_W'($urandom), random_value());
            n++;
         end
         if (!paused && n >= count / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      idle_pct      = 15;
      error_count   = 0;
      sent_count    = 0;
      compute_count = 0;
      checked_count = 0;
      for (int k = 0; k < mm4_pkg::ELEMS; k++) begin
         left_mat[k]  = '0;
         right_mat[k] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_product();
      test_ignored_codes();
      test_floor_rounding();
      test_saturation();
      test_random_traffic(15, 110);
      test_random_traffic(86, 110);
      test_random_traffic(0, 110);

      // Let the last products drain, then give the pipeline time to settle
      start = 1'b0;
      while (product_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d requests, %0d of them computes; checked %0d product elements.",
               sent_count, compute_count, checked_count);
      $display("Covered rounding, saturation, ignored codes and three sender idle rates.");
      if (error_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
